FILE: hw/rtl/ftlwl_pkg.sv
// ----------------------------------------------------------------------------
// ftlwl_pkg
// types, codes and defaults shared by the wear-levelling translation engine
// ----------------------------------------------------------------------------
package ftlwl_pkg;

    localparam int PHYS_BLOCKS_DEF = 32;
    localparam int WEAR_WIDTH_DEF  = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [5:0] UNMAPPED = 6'd63;

    localparam logic [4:0] LC_RESET = 5'd31;
    localparam logic [5:0] PC_RESET = 6'd32;
    localparam logic [7:0] EB_RESET = 8'd255;

    typedef enum logic [1:0] {
        REG_LOGICAL_COUNT  = 2'd0,
        REG_PHYSICAL_COUNT = 2'd1,
        REG_ERASED_BYTE    = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TRIM  = 2'd2,
        ACT_BAD   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CMD_STATUS  = 3'd0,
        CMD_READ    = 3'd1,
        CMD_FILL    = 3'd2,
        CMD_ERASE   = 3'd3,
        CMD_PROGRAM = 3'd4
    } command_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_RANGE   = 2'd1,
        STS_NOBLOCK = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BLK_FREE  = 2'd0,
        BLK_LIVE  = 2'd1,
        BLK_STALE = 2'd2
    } blk_state_t;

    typedef enum logic [2:0] {
        EK_STATUS     = 3'd0,
        EK_READ       = 3'd1,
        EK_ERASE_PTR  = 3'd2,
        EK_ERASE_BEST = 3'd3,
        EK_PROG_BEST  = 3'd4
    } emit_kind_t;

    typedef struct packed {
        logic       load;
        logic       ptr_clr;
        logic       ptr_inc;
        logic       scan;
        logic       reclaim;
        logic       bump_best;
        logic       commit;
        logic       trim_step;
        logic       emit;
        emit_kind_t kind;
        status_t    status;
    } ftlwl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    oor;
        logic    ptr_done;
        logic    trim_done;
        logic    cur_stale;
        logic    found;
        logic    out_free;
    } ftlwl_sts_t;

endpackage

FILE: hw/rtl/ftlwl_if.sv
// ----------------------------------------------------------------------------
// ftlwl channel interfaces
// request, result and configuration channels with valid/ready transfer
// ----------------------------------------------------------------------------
interface ftlwl_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [4:0] logical_block;
    logic [5:0] range_count;
    modport source (output valid, action, logical_block, range_count, input ready);
    modport sink   (input valid, action, logical_block, range_count, output ready);
endinterface

interface ftlwl_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [4:0] phys_block;
    logic [7:0] fill_byte;
    logic [1:0] status;
    logic       last;
    modport source (output valid, command, phys_block, fill_byte, status, last,
                    input ready);
    modport sink   (input valid, command, phys_block, fill_byte, status, last,
                    output ready);
endinterface

interface ftlwl_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ftlwl_ctrl.sv
// ----------------------------------------------------------------------------
// ftlwl_ctrl
// sequencer for read, write (scan, reclaim, rescan, erase, program) and trim
// ----------------------------------------------------------------------------
module ftlwl_ctrl
    import ftlwl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ftlwl_sts_t sts,
    output ftlwl_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CHECK   = 8'b0000_0010,
        S_SCAN    = 8'b0000_0100,
        S_RECLAIM = 8'b0000_1000,
        S_SCAN2   = 8'b0001_0000,
        S_ERASE   = 8'b0010_0000,
        S_PROG    = 8'b0100_0000,
        S_TRIM    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = EK_STATUS;
        cmd.status = STS_OK;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.oor)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.status = STS_RANGE;
                        state_next = S_IDLE;
                    end
                end
                else if (sts.action == ACT_READ)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = EK_READ;
                        state_next = S_IDLE;
                    end
                end
                else if (sts.action == ACT_WRITE)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_TRIM;
                end
            end
            S_SCAN, S_SCAN2:
            begin
                if (!sts.ptr_done)
                begin
                    cmd.scan    = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
                else if (sts.found)
                begin
                    state_next = S_ERASE;
                end
                else if (state_reg == S_SCAN)
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = S_RECLAIM;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = STS_NOBLOCK;
                    state_next = S_IDLE;
                end
            end
            S_RECLAIM:
            begin
                if (sts.ptr_done)
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = S_SCAN2;
                end
                else if (!sts.cur_stale)
                begin
                    cmd.ptr_inc = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.reclaim = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.kind    = EK_ERASE_PTR;
                end
            end
            S_ERASE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = EK_ERASE_BEST;
                    cmd.bump_best = 1'b1;
                    state_next    = S_PROG;
                end
            end
            S_PROG:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = EK_PROG_BEST;
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TRIM:
            begin
                if (!sts.trim_done)
                begin
                    cmd.trim_step = 1'b1;
                    cmd.ptr_inc   = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ftlwl_datapath.sv
// ----------------------------------------------------------------------------
// ftlwl_datapath
// map, block state and erase count tables, scan pointer and result register
// ----------------------------------------------------------------------------
module ftlwl_datapath
    import ftlwl_pkg::*;
#(
    parameter int PHYS_BLOCKS = PHYS_BLOCKS_DEF,
    parameter int WEAR_WIDTH  = WEAR_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ftlwl_cmd_t            cmd,
    output ftlwl_sts_t            sts,
    input  logic [1:0]            in_action,
    input  logic [4:0]            in_logical_block,
    input  logic [5:0]            in_range_count,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            out_command,
    output logic [4:0]            out_phys_block,
    output logic [7:0]            out_fill_byte,
    output logic [1:0]            out_status,
    output logic                  out_last
);

    // physical blocks beyond 32 cannot be named by the result field
    localparam int NB    = (PHYS_BLOCKS < 32) ? PHYS_BLOCKS : 32;
    localparam int IDX_W = $clog2(NB);

    logic [4:0] lc_reg;
    logic [5:0] pc_reg;
    logic [7:0] eb_reg;

    action_t    act_reg;
    logic [4:0] lbn_reg;
    logic [5:0] cnt_reg;
    logic [5:0] ptr_reg;

    logic                  found_reg;
    logic [IDX_W-1:0]      best_reg;
    logic [WEAR_WIDTH-1:0] best_wear_reg;

    logic [5:0]            map_reg  [32];
    blk_state_t            bst_reg  [NB];
    logic [WEAR_WIDTH-1:0] wear_reg [NB];

    logic                  out_valid_reg;
    logic [2:0]            out_command_reg;
    logic [4:0]            out_phys_reg;
    logic [7:0]            out_fill_reg;
    logic [1:0]            out_status_reg;
    logic                  out_last_reg;

    logic [5:0]            n_use;
    logic [IDX_W-1:0]      ptr_idx;
    logic [4:0]            map_addr;
    logic [5:0]            map_rd;
    blk_state_t            cur_bst;
    logic [IDX_W-1:0]      wear_addr;
    logic [WEAR_WIDTH-1:0] wear_rd;
    logic [WEAR_WIDTH-1:0] wear_inc;
    logic                  oor;
    logic                  mark_old;

    assign n_use    = (pc_reg > 6'(NB)) ? 6'(NB) : pc_reg;
    assign ptr_idx  = ptr_reg[IDX_W-1:0];
    assign map_addr = lbn_reg + ((act_reg == ACT_TRIM) ? ptr_reg[4:0] : 5'd0);
    assign map_rd   = map_reg[map_addr];
    assign cur_bst  = bst_reg[ptr_idx];
    assign wear_addr = cmd.bump_best ? best_reg : ptr_idx;
    assign wear_rd  = wear_reg[wear_addr];
    assign wear_inc = (wear_rd == {WEAR_WIDTH{1'b1}}) ? wear_rd : wear_rd + 1'b1;
    assign mark_old = (map_rd != UNMAPPED) && (map_rd < 6'(NB));

    always_comb
    begin
        unique case (act_reg)
            ACT_READ, ACT_WRITE: oor = (lbn_reg >= lc_reg);
            ACT_TRIM:            oor = (cnt_reg > {1'b0, lc_reg}) ||
                                       ({1'b0, lbn_reg} > ({1'b0, lc_reg} - cnt_reg));
            default:             oor = 1'b1;
        endcase
    end

    assign sts.action    = act_reg;
    assign sts.oor       = oor;
    assign sts.ptr_done  = (ptr_reg >= n_use);
    assign sts.trim_done = (ptr_reg == cnt_reg);
    assign sts.cur_stale = (cur_bst == BLK_STALE);
    assign sts.found     = found_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg <= LC_RESET;
            pc_reg <= PC_RESET;
            eb_reg <= EB_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_LOGICAL_COUNT:  lc_reg <= cfg_data[4:0];
                REG_PHYSICAL_COUNT: pc_reg <= cfg_data[5:0];
                REG_ERASED_BYTE:    eb_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // item registers, scan pointer and best candidate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= ACT_READ;
            ptr_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                act_reg <= action_t'(in_action);
            end
            if (cmd.load || cmd.ptr_clr)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.ptr_inc)
                begin
                    ptr_reg <= ptr_reg + 6'd1;
                end
                if (cmd.scan && cur_bst == BLK_FREE && (!found_reg || wear_rd < best_wear_reg))
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lbn_reg <= in_logical_block;
            cnt_reg <= in_range_count;
        end
        if (cmd.scan && cur_bst == BLK_FREE && (!found_reg || wear_rd < best_wear_reg))
        begin
            best_reg      <= ptr_idx;
            best_wear_reg <= wear_rd;
        end
    end

    // block tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
            begin
                map_reg[i] <= UNMAPPED;
            end
            for (int i = 0; i < NB; i++)
            begin
                bst_reg[i]  <= BLK_FREE;
                wear_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.reclaim)
            begin
                bst_reg[ptr_idx]  <= BLK_FREE;
                wear_reg[ptr_idx] <= wear_inc;
            end
            if (cmd.bump_best)
            begin
                wear_reg[best_reg] <= wear_inc;
            end
            if (cmd.commit)
            begin
                if (mark_old)
                begin
                    bst_reg[map_rd[IDX_W-1:0]] <= BLK_STALE;
                end
                bst_reg[best_reg]  <= BLK_LIVE;
                map_reg[map_addr]  <= 6'(best_reg);
            end
            if (cmd.trim_step && map_rd != UNMAPPED)
            begin
                if (mark_old)
                begin
                    bst_reg[map_rd[IDX_W-1:0]] <= BLK_STALE;
                end
                map_reg[map_addr] <= UNMAPPED;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_fill_reg   <= 8'd0;
            out_status_reg <= STS_OK;
            out_last_reg   <= 1'b1;
            out_phys_reg   <= 5'd0;
            case (cmd.kind)
                EK_READ:
                begin
                    if (map_rd == UNMAPPED)
                    begin
                        out_command_reg <= CMD_FILL;
                        out_fill_reg    <= eb_reg;
                    end
                    else
                    begin
                        out_command_reg <= CMD_READ;
                        out_phys_reg    <= map_rd[4:0];
                    end
                end
                EK_ERASE_PTR:
                begin
                    out_command_reg <= CMD_ERASE;
                    out_phys_reg    <= 5'(ptr_idx);
                    out_last_reg    <= 1'b0;
                end
                EK_ERASE_BEST:
                begin
                    out_command_reg <= CMD_ERASE;
                    out_phys_reg    <= 5'(best_reg);
                    out_last_reg    <= 1'b0;
                end
                EK_PROG_BEST:
                begin
                    out_command_reg <= CMD_PROGRAM;
                    out_phys_reg    <= 5'(best_reg);
                end
                default:
                begin
                    out_command_reg <= CMD_STATUS;
                    out_status_reg  <= cmd.status;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_command    = out_command_reg;
    assign out_phys_block = out_phys_reg;
    assign out_fill_byte  = out_fill_reg;
    assign out_status     = out_status_reg;
    assign out_last       = out_last_reg;

endmodule

FILE: hw/rtl/flash_translation_wear_leveler_top.sv
// ----------------------------------------------------------------------------
// flash_translation_wear_leveler_top
// logical-to-physical block remapping with least-worn free block selection
// ----------------------------------------------------------------------------
// a write scans the physical blocks in use for the least-worn free block and,
// when none is free, reclaims stale blocks and scans again; the wear scan
// visits one entry per cycle; one item is in flight at a time, and a stall
// on the result side holds the item until the result register is free
// reset: asynchronous, all blocks unmapped and free, erase counts zero,
// configuration at its reset values; no clearing pass
module flash_translation_wear_leveler_top
    import ftlwl_pkg::*;
#(
    parameter int PHYS_BLOCKS = PHYS_BLOCKS_DEF,
    parameter int WEAR_WIDTH  = WEAR_WIDTH_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    ftlwl_req_if.sink   req,
    ftlwl_rsp_if.source rsp,
    ftlwl_cfg_if.sink   cfg
);

    ftlwl_cmd_t cmd;
    ftlwl_sts_t sts;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    // sequencer: takes a request transfer only when idle
    ftlwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables and result register; the result register decouples the
    // result transfer from the next request
    ftlwl_datapath #(
        .PHYS_BLOCKS (PHYS_BLOCKS),
        .WEAR_WIDTH  (WEAR_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_action        (req.action),
        .in_logical_block (req.logical_block),
        .in_range_count   (req.range_count),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_command      (rsp.command),
        .out_phys_block   (rsp.phys_block),
        .out_fill_byte    (rsp.fill_byte),
        .out_status       (rsp.status),
        .out_last         (rsp.last)
    );

    // a request transfer makes the engine busy on the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    // error status only ever comes on a final status-only result
    a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STS_OK) |-> (rsp.last && rsp.command == CMD_STATUS))
        else $error("error status on a non-final result");

    // erase results are never final
    a_erase_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.command == CMD_ERASE) |-> !rsp.last)
        else $error("erase marked last");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the wear-levelling translation engine: a predictor
// holds its own map, block states and erase counts, every request transfer
// adds the expected command sequence, every result transfer is checked
// ----------------------------------------------------------------------------
module testbench;
    import ftlwl_pkg::*;

    localparam int IDLE_LIMIT = 2000;   // cycles without any transfer
    localparam int NBLK       = 32;

    typedef struct packed {
        command_t   command;
        logic [4:0] phys_block;
        logic [7:0] fill_byte;
        status_t    status;
        logic       last;
    } ftl_result_t;

    // predictor and store of expected commands
    class ftl_scoreboard;
        ftl_result_t  pending_q[$];
        int           lcount;
        int           pcount;
        logic [7:0]   erased;
        int           map_tbl [NBLK];
        blk_state_t   blk_st  [NBLK];
        logic [31:0]  erases  [NBLK];
        int           mismatches;
        int           results_seen;
        int           erase_cmds;
        int           noblock_seen;

        function new();
            lcount = LC_RESET;
            pcount = PC_RESET;
            erased = EB_RESET;
            foreach (map_tbl[i])
            begin
                map_tbl[i] = UNMAPPED;
                blk_st[i]  = BLK_FREE;
                erases[i]  = '0;
            end
        endfunction

        function void set_reg(reg_idx_t idx, logic [7:0] value);
            case (idx)
                REG_LOGICAL_COUNT:  lcount = value[4:0];
                REG_PHYSICAL_COUNT: pcount = value[5:0];
                REG_ERASED_BYTE:    erased = value;
                default: ;
            endcase
        endfunction

        function void push(command_t c, int p, logic [7:0] f, status_t s, logic l);
            ftl_result_t r;
            r.command    = c;
            r.phys_block = p[4:0];
            r.fill_byte  = f;
            r.status     = s;
            r.last       = l;
            pending_q.push_back(r);
        endfunction

        function int blocks_in_use();
            return (pcount > NBLK) ? NBLK : pcount;
        endfunction

        // least-worn free block, lowest index on a tie; -1 when none
        function int least_worn_free();
            int best;
            best = -1;
            for (int p = 0; p < blocks_in_use(); p++)
                if (blk_st[p] == BLK_FREE && (best < 0 || erases[p] < erases[best]))
                    best = p;
            return best;
        endfunction

        function void wear(int p);
            if (erases[p] != '1)
                erases[p] = erases[p] + 1;
        endfunction

        function void write_block(int lbn);
            int ph;
            ph = least_worn_free();
            if (ph < 0)
            begin
                for (int p = 0; p < blocks_in_use(); p++)
                    if (blk_st[p] == BLK_STALE)
                    begin
                        push(CMD_ERASE, p, 8'd0, STS_OK, 1'b0);
                        wear(p);
                        blk_st[p] = BLK_FREE;
                    end
                ph = least_worn_free();
                if (ph < 0)
                begin
                    push(CMD_STATUS, 0, 8'd0, STS_NOBLOCK, 1'b1);
                    return;
                end
            end
            push(CMD_ERASE, ph, 8'd0, STS_OK, 1'b0);
            wear(ph);
            push(CMD_PROGRAM, ph, 8'd0, STS_OK, 1'b1);
            if (map_tbl[lbn] != UNMAPPED)
                blk_st[map_tbl[lbn]] = BLK_STALE;
            blk_st[ph]   = BLK_LIVE;
            map_tbl[lbn] = ph;
        endfunction

        function void note_request(action_t act, logic [4:0] lbn, logic [5:0] cnt);
            int l;
            if (act == ACT_READ || act == ACT_WRITE)
            begin
                if (lbn >= lcount)
                    push(CMD_STATUS, 0, 8'd0, STS_RANGE, 1'b1);
                else if (act == ACT_WRITE)
                    write_block(lbn);
                else if (map_tbl[lbn] == UNMAPPED)
                    push(CMD_FILL, 0, erased, STS_OK, 1'b1);
                else
                    push(CMD_READ, map_tbl[lbn], 8'd0, STS_OK, 1'b1);
            end
            else if (act == ACT_TRIM)
            begin
                if (cnt > lcount || lbn > lcount - cnt)
                    push(CMD_STATUS, 0, 8'd0, STS_RANGE, 1'b1);
                else
                begin
                    for (int i = 0; i < cnt; i++)
                    begin
                        l = (lbn + i) % NBLK;
                        if (map_tbl[l] != UNMAPPED)
                        begin
                            blk_st[map_tbl[l]] = BLK_STALE;
                            map_tbl[l] = UNMAPPED;
                        end
                    end
                    push(CMD_STATUS, 0, 8'd0, STS_OK, 1'b1);
                end
            end
            else
                push(CMD_STATUS, 0, 8'd0, STS_RANGE, 1'b1);
        endfunction

        function void check_result(ftl_result_t got);
            ftl_result_t want;
            results_seen++;
            if (got.command == CMD_ERASE)
                erase_cmds++;
            if (got.status == STS_NOBLOCK)
                noblock_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cmd %0d phys %0d fill %0d sts %0d last %0d",
                             got.command, got.phys_block, got.fill_byte, got.status,
                             got.last);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected cmd %0d phys %0d fill %0d sts %0d last %0d, got cmd %0d phys %0d fill %0d sts %0d last %0d",
                             want.command, want.phys_block, want.fill_byte, want.status,
                             want.last, got.command, got.phys_block, got.fill_byte,
                             got.status, got.last);
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ftlwl_req_if req_ch ();
    ftlwl_rsp_if rsp_ch ();
    ftlwl_cfg_if cfg_ch ();

    flash_translation_wear_leveler_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    ftl_scoreboard sb = new();

    int idle_pct   = 33;   // chance in a hundred of a gap on either side
    int hold_off   = 0;    // long receiver stall, counted down by the receiver
    int requests   = 0;
    int quiet      = 0;

    // clock: high then low, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // every input known from the start
    initial
    begin
        req_ch.valid         = 1'b0;
        req_ch.action        = ACT_READ;
        req_ch.logical_block = '0;
        req_ch.range_count   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_LOGICAL_COUNT;
        cfg_ch.data          = '0;
        rsp_ch.ready         = 1'b0;
    end

    // receiver: check each result transfer, then decide ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result({command_t'(rsp_ch.command), rsp_ch.phys_block,
                                 rsp_ch.fill_byte, status_t'(rsp_ch.status),
                                 rsp_ch.last});
            if (hold_off > 0)
            begin
                hold_off--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog: any transfer restarts the count
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // one request transfer, with random gaps ahead of it
    task automatic send_request(action_t act, logic [4:0] lbn, logic [5:0] cnt);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.logical_block <= lbn;
        req_ch.range_count   <= cnt;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(act, lbn, cnt);
        requests++;
    endtask

    // wait until every expected command has come back, then let the block settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    // mostly well-formed traffic inside the logical range, some noise
    task automatic random_traffic(int count);
        int         pick;
        int         lc;
        logic [5:0] cnt;
        logic [4:0] lbn;
        lc = sb.lcount;
        repeat (count)
        begin
            pick = $urandom_range(99);
            lbn  = (lc > 0) ? $urandom_range(lc - 1) : 5'd0;
            if (pick < 45)
                send_request(ACT_WRITE, lbn, 6'($urandom_range(63)));
            else if (pick < 72)
                send_request(ACT_READ, lbn, 6'($urandom_range(63)));
            else if (pick < 86)
            begin
                cnt = $urandom_range(lc);
                send_request(ACT_TRIM, 5'($urandom_range(lc - cnt)), cnt);
            end
            else
                send_request(action_t'($urandom_range(3)), 5'($urandom_range(31)),
                             6'($urandom_range(63)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset settings: fill, copy-on-write, bounds, trims
        send_request(ACT_READ,  5'd0,  6'd0);
        send_request(ACT_WRITE, 5'd0,  6'd63);
        send_request(ACT_READ,  5'd0,  6'd0);
        send_request(ACT_WRITE, 5'd0,  6'd0);
        send_request(ACT_WRITE, 5'd30, 6'd0);
        send_request(ACT_READ,  5'd30, 6'd0);
        send_request(ACT_READ,  5'd31, 6'd0);
        send_request(ACT_WRITE, 5'd31, 6'd0);
        send_request(ACT_TRIM,  5'd0,  6'd0);
        send_request(ACT_TRIM,  5'd31, 6'd0);
        send_request(ACT_TRIM,  5'd30, 6'd1);
        send_request(ACT_READ,  5'd30, 6'd0);
        send_request(ACT_TRIM,  5'd0,  6'd31);
        send_request(ACT_READ,  5'd0,  6'd0);
        send_request(ACT_TRIM,  5'd1,  6'd31);
        send_request(ACT_TRIM,  5'd0,  6'd32);
        send_request(ACT_TRIM,  5'd31, 6'd63);
        send_request(ACT_BAD,   5'd31, 6'd63);
        send_request(ACT_BAD,   5'd0,  6'd0);
        drain();

        // tiny device: reclaim and reuse of stale blocks, no idling at first
        write_reg(REG_LOGICAL_COUNT, 8'd3);
        write_reg(REG_PHYSICAL_COUNT, 8'd4);
        write_reg(REG_ERASED_BYTE, 8'd0);
        write_reg(REG_UNUSED, 8'hff);
        idle_pct = 0;
        random_traffic(12);
        idle_pct = 33;
        random_traffic(14);
        drain();

        // no spare block: writes run out of room
        write_reg(REG_LOGICAL_COUNT, 8'd31);
        write_reg(REG_PHYSICAL_COUNT, 8'd2);
        write_reg(REG_ERASED_BYTE, 8'($urandom_range(255)));
        random_traffic(14);
        drain();

        // degenerate physical counts
        write_reg(REG_PHYSICAL_COUNT, 8'd1);
        random_traffic(5);
        drain();
        write_reg(REG_PHYSICAL_COUNT, 8'd0);
        write_reg(REG_LOGICAL_COUNT, 8'd0);
        random_traffic(5);
        drain();

        // oversized physical count with a long result stall
        write_reg(REG_LOGICAL_COUNT, 8'd20);
        write_reg(REG_PHYSICAL_COUNT, 8'hff);
        write_reg(REG_ERASED_BYTE, 8'hff);
        hold_off = 300;
        random_traffic(45);
        drain();

        $display("covered %0d requests and %0d results, %0d erases, %0d out-of-space",
                 requests, sb.results_seen, sb.erase_cmds, sb.noblock_seen);
        $display("mismatches %0d, leftover expectations %0d",
                 sb.mismatches, sb.pending_q.size());
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
